/* hdl/spc_pkg.sv */
// Shared types, constants and arithmetic helpers for the solar position pipeline.
`timescale 1ns / 1ps

package spc_pkg;

	// Angle format on the ports: degrees * 2^ANGLE_FRAC_BITS
	localparam int ANGLE_FRAC_BITS   = 10;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_TABLE_LEN    = 24;

	// Internal angle format: degrees * 2^IFRAC
	localparam int IFRAC   = 20;
	localparam int ANG_W   = 32;
	localparam int TRIG_W  = 32;   // Q30 sine/cosine
	localparam int VAL_W   = 34;   // Q30 sums and CORDIC datapath
	localparam int S_W     = 32;   // clamped sine of elevation
	localparam int PROD_W  = 64;
	localparam int ISQ_W   = 63;
	localparam int ISQ_STAGES = 31;
	localparam int ROOT_W  = 31;
	localparam int SQ_W    = 62;

	localparam int LAT_W = 18;
	localparam int LON_W = 19;
	localparam int EL_W  = 18;
	localparam int AZ_W  = 19;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 19;

	localparam logic [CFG_INDEX_W-1:0] REG_SITE_LATITUDE  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SITE_LONGITUDE = 4'd1;

	typedef logic signed [ANG_W-1:0]  angle_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	localparam angle_t DEG90  = 32'sd94371840;
	localparam angle_t DEG180 = 32'sd188743680;
	localparam angle_t DEG360 = 32'sd377487360;

	localparam val_t CORDIC_GAIN = 34'sd652032874;
	localparam val_t ONE_Q30     = 34'sd1073741824;

	localparam prod_t EL_LIMIT = prod_t'(90) <<< ANGLE_FRAC_BITS;
	localparam prod_t AZ_FULL  = prod_t'(360) <<< ANGLE_FRAC_BITS;

	typedef struct packed {
		logic [8:0]  day_of_year;
		logic [10:0] minute_of_day;
	} sample_t;

	typedef struct packed {
		logic signed [EL_W-1:0] sun_elevation;
		logic [AZ_W-1:0]        sun_azimuth;
	} result_t;

	// atan(2^-i) in degrees * 2^20
	localparam angle_t ATAN_DEG [ATAN_TABLE_LEN] = '{
		32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
		32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
		32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
		32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
		32'sd917,      32'sd458,      32'sd229,      32'sd115,
		32'sd57,       32'sd29,       32'sd14,       32'sd7
	};

	// Bring an angle into [-180, 180); inputs stay within three turns
	function automatic angle_t wrap180(input angle_t v);
		angle_t r;
		r = v;
		for (int i = 0; i < 3; i++) begin
			if (r >= DEG180)
				r = r - DEG360;
			else if (r < -DEG180)
				r = r + DEG360;
		end
		return r;
	endfunction

	// v / 2^sh rounded half away from zero
	function automatic prod_t round_away(input prod_t v, input int sh);
		prod_t half;
		prod_t r;
		half = '0;
		half[sh-1] = 1'b1;
		if (!v[PROD_W-1])
			r = (v + half) >>> sh;
		else
			r = -((-v + half) >>> sh);
		return r;
	endfunction

endpackage

/* hdl/spc_sample_if.sv */
// Input channel: one day/minute sample per beat.
`timescale 1ns / 1ps

interface spc_sample_if import spc_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/spc_result_if.sv */
// Output channel: one elevation/azimuth pair per beat.
`timescale 1ns / 1ps

interface spc_result_if import spc_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/spc_cfg_if.sv */
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface spc_cfg_if import spc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* hdl/spc_delay.sv */
// Enabled shift line that aligns side data with a pipelined unit.
`timescale 1ns / 1ps

module spc_delay import spc_pkg::*; #(
	parameter int W     = 32,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] d_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= din;
			for (int i = 1; i < DEPTH; i++)
				d_s[i] <= d_s[i-1];
		end
	end

	assign dout = d_s[DEPTH-1];

endmodule

/* hdl/spc_sincos.sv */
// Pipelined rotation CORDIC: sine and cosine of an angle in degrees * 2^20.
`timescale 1ns / 1ps

module spc_sincos import spc_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic   clk,
	input  logic   en,
	input  angle_t angle,
	output trig_t  sin_out,
	output trig_t  cos_out
);

	val_t   x_s   [STAGES+1];
	val_t   y_s   [STAGES+1];
	angle_t z_s   [STAGES+1];
	logic   neg_s [STAGES+1];
	trig_t  sin_sout;
	trig_t  cos_sout;
	angle_t zw;

	assign zw = wrap180(angle);

	// fold into [-90, 90] and remember the sign flip
	always_ff @(posedge clk) begin
		if (en) begin
			if (zw > DEG90) begin
				z_s[0]   <= zw - DEG180;
				neg_s[0] <= 1'b1;
			end else if (zw < -DEG90) begin
				z_s[0]   <= zw + DEG180;
				neg_s[0] <= 1'b1;
			end else begin
				z_s[0]   <= zw;
				neg_s[0] <= 1'b0;
			end
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][ANG_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_DEG[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_DEG[i];
				end
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_sout <= neg_s[STAGES] ? TRIG_W'(-y_s[STAGES]) : TRIG_W'(y_s[STAGES]);
			cos_sout <= neg_s[STAGES] ? TRIG_W'(-x_s[STAGES]) : TRIG_W'(x_s[STAGES]);
		end
	end

	assign sin_out = sin_sout;
	assign cos_out = cos_sout;

endmodule

/* hdl/spc_atan2.sv */
// Pipelined vectoring CORDIC: atan2(y, x) in degrees * 2^20.
`timescale 1ns / 1ps

module spc_atan2 import spc_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic   clk,
	input  logic   en,
	input  val_t   y_in,
	input  val_t   x_in,
	output angle_t angle
);

	localparam int AT_W = VAL_W + 3;

	logic signed [AT_W-1:0] x_s [STAGES+1];
	logic signed [AT_W-1:0] y_s [STAGES+1];
	angle_t                 z_s [STAGES+1];
	logic                   zero_s [STAGES+1];
	angle_t                 ang_sout;
	logic signed [AT_W-1:0] xe, ye;

	assign xe = AT_W'(x_in);
	assign ye = AT_W'(y_in);

	// rotate by +-90 when x is negative
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (xe[AT_W-1]) begin
				if (!ye[AT_W-1]) begin
					y_s[0] <= -xe;
					x_s[0] <= ye;
					z_s[0] <= DEG90;
				end else begin
					y_s[0] <= xe;
					x_s[0] <= -ye;
					z_s[0] <= -DEG90;
				end
			end else begin
				y_s[0] <= ye;
				x_s[0] <= xe;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][AT_W-1] && (y_s[i] != '0)) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_DEG[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_DEG[i];
				end
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			ang_sout <= zero_s[STAGES] ? '0 : z_s[STAGES];
	end

	assign angle = ang_sout;

endmodule

/* hdl/spc_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module spc_isqrt import spc_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [ISQ_W-1:0]  radicand,
	output logic [ROOT_W-1:0] root
);

	logic [ISQ_W-1:0]  rem_s  [ISQ_STAGES+1];
	logic [ROOT_W-1:0] root_s [ISQ_STAGES+1];

	assign rem_s[0]  = radicand;
	assign root_s[0] = '0;

	for (genvar j = 0; j < ISQ_STAGES; j++) begin : g_bit
		localparam int K = ISQ_STAGES - 1 - j;
		logic [ISQ_W-1:0] trial;
		// (r + 2^k)^2 - r^2
		assign trial = (ISQ_W'(root_s[j]) << (K + 1)) + (ISQ_W'(1) << (2 * K));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[j] >= trial) begin
					rem_s[j+1]  <= rem_s[j] - trial;
					root_s[j+1] <= root_s[j] | (ROOT_W'(1) << K);
				end else begin
					rem_s[j+1]  <= rem_s[j];
					root_s[j+1] <= root_s[j];
				end
			end
		end
	end

	assign root = root_s[ISQ_STAGES];

endmodule

/* hdl/solar_position_calc.sv */
// Top level of the solar elevation/azimuth pipeline.
// Usage:
//   cfg    : write register 0 (site latitude) or 1 (site longitude), degrees * 1024,
//            one write per beat; ready is always high. Write only while the pipe is empty.
//   sample : one beat carries a UTC day of year and minute of day.
//   result : one beat per sample, in order: sun elevation and azimuth, degrees * 1024.
// Throughput: one sample per cycle, every cycle, as long as results are taken.
// Pipe: from sample beat to result valid the data passes three CORDIC pipes in series
//   (day-angle sine/cosine, declination sine/cosine, arctangent), the pipelined square
//   root (31 stages), 13 single-register stages and the output register.
// Stall: the whole pipe advances together; a two-entry output buffer (output register
//   plus skid register) absorbs one beat when result.ready drops, and sample.ready
//   comes straight from a flop, so it falls once the skid register fills. Nothing is lost or repeated.
// Reset: arst_n clears the valid bits, the output buffer's valid flags and both site registers (0, 0).
`timescale 1ns / 1ps

module solar_position_calc import spc_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	spc_sample_if.sink   sample,
	spc_result_if.source result,
	spc_cfg_if.sink      cfg
);

	localparam int LAT_SC    = CORDIC_STAGES + 2;
	localparam int LAT_AT    = CORDIC_STAGES + 2;
	localparam int LAT_TOTAL = 4 + LAT_SC + 2 + LAT_SC + 6 + ISQ_STAGES + LAT_AT + 1;
	localparam int SCALE_SH  = IFRAC - ANGLE_FRAC_BITS;
	localparam int MIN_SH    = IFRAC - 2;   // minute * 15/60 deg
	localparam int N_W       = 17;
	localparam int Q_W       = 10;
	localparam int BASE_W    = 29;
	localparam logic signed [25:0] DECL_AMP = -26'sd24578621;   // -23.44 deg * 2^20
	localparam logic [ISQ_W-1:0]   ONE_Q60  = ISQ_W'(1) << 60;

	logic en;

	// ---------------- configuration ----------------
	logic signed [LAT_W-1:0] lat_q;
	logic signed [LON_W-1:0] lon_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q <= '0;
			lon_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SITE_LATITUDE:  lat_q <= cfg.wdata[LAT_W-1:0];
				REG_SITE_LONGITUDE: lon_q <= cfg.wdata[LON_W-1:0];
				default: ;   // drop writes beyond the register list
			endcase
		end
	end

	// ---------------- valid bits ----------------
	// Travel in lockstep with the data; every stage holds while en is low.
	logic [LAT_TOTAL-1:0] vld_q;

	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT_TOTAL-2:0], sample.valid};
	end

	// ---------------- stage 1: day wrap, hour angle, latitude ----------------
	// (day + 10) mod 365 leaves the declination angle unchanged modulo 360 deg.
	logic [9:0]     d10;
	logic [8:0]     m_s1;
	angle_t         ha_s1, lat_s1;

	assign d10 = {1'b0, sample.data.day_of_year} + 10'd10;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= (d10 >= 10'd365) ? 9'(d10 - 10'd365) : d10[8:0];
			ha_s1  <= (ANG_W'(sample.data.minute_of_day) << MIN_SH)
			        + (ANG_W'(lon_q) <<< SCALE_SH) - DEG180;
			lat_s1 <= ANG_W'(lat_q) <<< SCALE_SH;
		end
	end

	// ---------------- stages 2-4: day angle = floor((m*360*2^20 + 182) / 365) ----------------
	// Split as m*1034211 + floor((345*m + 182) / 365); the remainder quotient uses a
	// reciprocal multiply that is low by at most one, then one compare fixes it.
	logic [N_W-1:0]    n_s2, n_s3;
	logic [BASE_W-1:0] base_s2, base_s3;
	logic [Q_W-1:0]    q0_s3;
	angle_t            ha_s2, ha_s3, ha_s4, lat_s2, lat_s3, lat_s4, dang_s4;
	logic [N_W-1:0]    rem3;
	logic [Q_W-1:0]    q3;

	assign rem3 = n_s3 - N_W'(q0_s3) * N_W'(365);
	assign q3   = q0_s3 + ((rem3 >= N_W'(365)) ? Q_W'(1) : Q_W'(0));

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2    <= N_W'(m_s1) * N_W'(345) + N_W'(182);
			base_s2 <= BASE_W'(m_s1) * BASE_W'(1034211);
			ha_s2   <= ha_s1;
			lat_s2  <= lat_s1;

			q0_s3   <= Q_W'((32'(n_s2) * 32'd11491) >> 22);
			n_s3    <= n_s2;
			base_s3 <= base_s2;
			ha_s3   <= ha_s2;
			lat_s3  <= lat_s2;

			dang_s4 <= ANG_W'(base_s3) + ANG_W'(q3);
			ha_s4   <= ha_s3;
			lat_s4  <= lat_s3;
		end
	end

	// ---------------- first trig bank ----------------
	trig_t cos_day, sl, cl, sh, ch;

	spc_sincos #(.STAGES(CORDIC_STAGES)) u_sc_day (
		.clk(clk), .en(en), .angle(dang_s4), .sin_out(), .cos_out(cos_day)
	);
	spc_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat (
		.clk(clk), .en(en), .angle(lat_s4), .sin_out(sl), .cos_out(cl)
	);
	spc_sincos #(.STAGES(CORDIC_STAGES)) u_sc_ha (
		.clk(clk), .en(en), .angle(ha_s4), .sin_out(sh), .cos_out(ch)
	);

	// ---------------- stages 5-6: declination ----------------
	prod_t  dprod_s5;
	angle_t decl_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			dprod_s5 <= prod_t'(DECL_AMP) * prod_t'(cos_day);
			decl_s6  <= ANG_W'(round_away(dprod_s5, 30));
		end
	end

	trig_t sd, cd;

	spc_sincos #(.STAGES(CORDIC_STAGES)) u_sc_decl (
		.clk(clk), .en(en), .angle(decl_s6), .sin_out(sd), .cos_out(cd)
	);

	// Hold latitude and hour-angle trig until the declination trig catches up.
	logic [4*TRIG_W-1:0] trig_d;
	trig_t               sl_d, cl_d, sh_d, ch_d;

	spc_delay #(.W(4 * TRIG_W), .DEPTH(LAT_SC + 2)) u_dly_trig (
		.clk(clk), .en(en), .din({sl, cl, sh, ch}), .dout(trig_d)
	);

	assign sl_d = trig_d[4*TRIG_W-1:3*TRIG_W];
	assign cl_d = trig_d[3*TRIG_W-1:2*TRIG_W];
	assign sh_d = trig_d[2*TRIG_W-1:TRIG_W];
	assign ch_d = trig_d[TRIG_W-1:0];

	// ---------------- stages 7-10: spherical products ----------------
	prod_t p_slsd_s7, p_clcd_s7, p_shcd_s7, p_chsl_s7, p_sdcl_s7;
	trig_t ch_s7, cd_s7, ch_s8, cd_s8;
	val_t  a_s8, b_s8, e_s8, f_s8, g_s8;
	prod_t p_bch_s9, p_fcd_s9;
	val_t  a_s9, e_s9, g_s9;
	val_t  sum9;
	logic signed [S_W-1:0] s_s10;
	val_t  ax_s10, ay_s10;

	assign sum9 = a_s9 + VAL_W'(round_away(p_bch_s9, 30));

	always_ff @(posedge clk) begin
		if (en) begin
			p_slsd_s7 <= prod_t'(sl_d) * prod_t'(sd);
			p_clcd_s7 <= prod_t'(cl_d) * prod_t'(cd);
			p_shcd_s7 <= prod_t'(sh_d) * prod_t'(cd);
			p_chsl_s7 <= prod_t'(ch_d) * prod_t'(sl_d);
			p_sdcl_s7 <= prod_t'(sd) * prod_t'(cl_d);
			ch_s7     <= ch_d;
			cd_s7     <= cd;

			a_s8  <= VAL_W'(round_away(p_slsd_s7, 30));
			b_s8  <= VAL_W'(round_away(p_clcd_s7, 30));
			e_s8  <= VAL_W'(round_away(p_shcd_s7, 30));
			f_s8  <= VAL_W'(round_away(p_chsl_s7, 30));
			g_s8  <= VAL_W'(round_away(p_sdcl_s7, 30));
			ch_s8 <= ch_s7;
			cd_s8 <= cd_s7;

			p_bch_s9 <= prod_t'(b_s8) * prod_t'(ch_s8);
			p_fcd_s9 <= prod_t'(f_s8) * prod_t'(cd_s8);
			a_s9     <= a_s8;
			e_s9     <= e_s8;
			g_s9     <= g_s8;

			// clamp sine of elevation to [-1, 1]
			if (sum9 > ONE_Q30)
				s_s10 <= S_W'(ONE_Q30);
			else if (sum9 < -ONE_Q30)
				s_s10 <= S_W'(-ONE_Q30);
			else
				s_s10 <= S_W'(sum9);
			ax_s10 <= VAL_W'(round_away(p_fcd_s9, 30)) - g_s9;
			ay_s10 <= e_s9;
		end
	end

	// ---------------- stages 11-12: cosine of elevation radicand ----------------
	logic [SQ_W-1:0]  sq_s11;
	logic [ISQ_W-1:0] v_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s11 <= SQ_W'(prod_t'(s_s10) * prod_t'(s_s10));
			v_s12  <= ONE_Q60 - ISQ_W'(sq_s11);
		end
	end

	logic [ROOT_W-1:0] c_root;

	spc_isqrt u_isqrt (
		.clk(clk), .en(en), .radicand(v_s12), .root(c_root)
	);

	// Carry the sine and azimuth vector past stages 11-12 and the square root.
	logic [S_W+2*VAL_W-1:0] vec_d;
	logic signed [S_W-1:0]  s_d;
	val_t                   ax_d, ay_d;

	spc_delay #(.W(S_W + 2 * VAL_W), .DEPTH(ISQ_STAGES + 2)) u_dly_vec (
		.clk(clk), .en(en), .din({s_s10, ax_s10, ay_s10}), .dout(vec_d)
	);

	assign s_d  = vec_d[S_W+2*VAL_W-1:2*VAL_W];
	assign ax_d = vec_d[2*VAL_W-1:VAL_W];
	assign ay_d = vec_d[VAL_W-1:0];

	// ---------------- arctangents ----------------
	angle_t z_el, z_az;

	spc_atan2 #(.STAGES(CORDIC_STAGES)) u_at_el (
		.clk(clk), .en(en), .y_in(VAL_W'(s_d)), .x_in(val_t'({1'b0, c_root})), .angle(z_el)
	);
	spc_atan2 #(.STAGES(CORDIC_STAGES)) u_at_az (
		.clk(clk), .en(en), .y_in(ay_d), .x_in(ax_d), .angle(z_az)
	);

	// ---------------- stage 13: round to port format ----------------
	prod_t el_r, az_r;
	logic signed [EL_W-1:0] el_s13;
	logic [AZ_W-1:0]        az_s13;

	assign el_r = round_away(prod_t'(z_el), SCALE_SH);
	assign az_r = round_away(prod_t'(z_az) + prod_t'(DEG180), SCALE_SH);

	always_ff @(posedge clk) begin
		if (en) begin
			if (el_r > EL_LIMIT)
				el_s13 <= EL_W'(EL_LIMIT);
			else if (el_r < -EL_LIMIT)
				el_s13 <= EL_W'(-EL_LIMIT);
			else
				el_s13 <= EL_W'(el_r);

			// wrap to [0, 360): rounding can land exactly on 360
			if (az_r >= AZ_FULL)
				az_s13 <= AZ_W'(az_r - AZ_FULL);
			else if (az_r[PROD_W-1])
				az_s13 <= AZ_W'(az_r + AZ_FULL);
			else
				az_s13 <= AZ_W'(az_r);
		end
	end

	// ---------------- output register and skid ----------------
	result_t out_q, skid_q, res_new;
	logic    out_v_q, skid_v_q;

	assign res_new = '{sun_elevation: el_s13, sun_azimuth: az_s13};

	// Advance the pipe whenever the skid slot is empty.
	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (result.ready)
				skid_v_q <= 1'b0;
		end else if (vld_q[LAT_TOTAL-1]) begin
			if (!out_v_q || result.ready)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (result.ready)
				out_q <= skid_q;
		end else if (vld_q[LAT_TOTAL-1]) begin
			if (!out_v_q || result.ready)
				out_q <= res_new;
			else
				skid_q <= res_new;
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;

endmodule

/* hdl/spc_sva.sv */
// Port-level checks for the solar position block, bound to the top level.
`timescale 1ns / 1ps

module spc_sva import spc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res_data
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result payload changed while stalled");

	a_el_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (prod_t'(res_data.sun_elevation) <= EL_LIMIT)
		           && (prod_t'(res_data.sun_elevation) >= -EL_LIMIT))
		else $error("elevation beyond +-90 degrees");

	a_az_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (prod_t'({1'b0, res_data.sun_azimuth}) < AZ_FULL))
		else $error("azimuth not wrapped below 360 degrees");

endmodule

bind solar_position_calc spc_sva u_spc_sva (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_data(result.data)
);

/* tb/tb_top.sv */
// Self-checking bench for the solar elevation/azimuth pipeline.
`timescale 1ns / 1ps

module tb_top;
	import spc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spc_sample_if sample_ch ();
	spc_result_if result_ch ();
	spc_cfg_if    cfg_ch ();

	solar_position_calc dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch.sink),
		.result (result_ch.source),
		.cfg    (cfg_ch.sink)
	);

	always #5 clk = ~clk;

	// Site registers as the predictor sees them (degrees * 1024)
	longint site_lat;
	longint site_lon;

	sample_t pending_samples [$];
	result_t expected_pos [$];
	int      mismatch_count;
	longint  cycle_count = 0;
	int      send_wait;
	int      recv_wait;

	localparam longint LIMIT_CYCLES = 2000000;
	localparam int     DRAIN_CYCLES = 200;

	// atan(2^-i) in degrees * 2^20
	longint atan_tab [24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_half(longint v, int s);
		longint half;
		half = 64'sd1 <<< (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return round_half(a * b, 30);
	endfunction

	function automatic longint fold180(longint v);
		longint full;
		longint r;
		full = 64'sd360 <<< 20;
		r = v % full;
		if (r < 0)
			r += full;
		if (r >= (64'sd180 <<< 20))
			r -= full;
		return r;
	endfunction

	// Rotation CORDIC after folding the angle into [-90, 90]
	task automatic rotate_sincos(input longint ang, output longint sn, output longint cs);
		longint z;
		longint x;
		longint y;
		longint t;
		bit flip;
		z = fold180(ang);
		x = 652032874;
		y = 0;
		flip = 1'b0;
		if (z > (64'sd90 <<< 20)) begin
			z -= 64'sd180 <<< 20;
			flip = 1'b1;
		end else if (z < -(64'sd90 <<< 20)) begin
			z += 64'sd180 <<< 20;
			flip = 1'b1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				t = x - floor_shift(y, i); y = y + floor_shift(x, i); x = t; z -= atan_tab[i];
			end else begin
				t = x + floor_shift(y, i); y = y - floor_shift(x, i); x = t; z += atan_tab[i];
			end
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endtask

	function automatic longint vector_atan2(longint yi, longint xi);
		longint x;
		longint y;
		longint z;
		longint t;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = y; y = -x; x = t; z = 64'sd90 <<< 20;
			end else begin
				t = -y; y = x; x = t; z = -(64'sd90 <<< 20);
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (y > 0) begin
				t = x + floor_shift(y, i); y = y - floor_shift(x, i); x = t; z += atan_tab[i];
			end else begin
				t = x - floor_shift(y, i); y = y + floor_shift(x, i); x = t; z -= atan_tab[i];
			end
		end
		return z;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// Sun position for one sample at the current site
	task automatic predict_position(input sample_t smp, output result_t res);
		longint dang, sda, cda, decl, ha;
		longint sl, cl, sd, cd, sh, ch, s, c, el, az, ay, ax;
		longint one;
		one = 64'sd1 <<< 30;
		dang = ((longint'(smp.day_of_year) + 10) * (64'sd360 <<< 20) + 182) / 365;
		rotate_sincos(dang, sda, cda);
		decl = round_half(-64'sd24578621 * cda, 30);
		ha = longint'(smp.minute_of_day) * (64'sd1 <<< 18) + (site_lon <<< 10)
			- (64'sd180 <<< 20);
		rotate_sincos(site_lat <<< 10, sl, cl);
		rotate_sincos(decl, sd, cd);
		rotate_sincos(ha, sh, ch);
		s = qmul(sl, sd) + qmul(qmul(cl, cd), ch);
		if (s > one) s = one;
		if (s < -one) s = -one;
		c = longint'(int_sqrt(longint'(one * one) - s * s));
		el = round_half(vector_atan2(s, c), 10);
		if (el > 92160) el = 92160;
		if (el < -92160) el = -92160;
		ay = qmul(sh, cd);
		ax = qmul(qmul(ch, sl), cd) - qmul(sd, cl);
		az = round_half(vector_atan2(ay, ax) + (64'sd180 <<< 20), 10);
		az %= 368640;
		if (az < 0) az += 368640;
		res.sun_elevation = el[EL_W-1:0];
		res.sun_azimuth   = az[AZ_W-1:0];
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want,
			cycle_count);
		mismatch_count++;
	endtask

	// Driver: hold each beat until accepted, then wait a random gap before the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.data  <= '0;
			send_wait <= 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				// Predict at acceptance so the site in force is the one used
				begin
					result_t r;
					predict_position(sample_ch.data, r);
					expected_pos.push_back(r);
				end
				void'(pending_samples.pop_front());
			end
			if (sample_ch.valid && !sample_ch.ready) begin
				// hold the beat
			end else if (send_wait > 0) begin
				sample_ch.valid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (pending_samples.size() != 0) begin
				sample_ch.valid <= 1'b1;
				sample_ch.data  <= pending_samples[0];
				if ($urandom_range(3) == 0)
					send_wait <= 0;
				else
					send_wait <= $urandom_range(14);
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: random stalls on ready, compare each accepted result in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_pos.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					result_t e;
					e = expected_pos.pop_front();
					if (result_ch.data.sun_elevation !== e.sun_elevation)
						report_mismatch("sun_elevation", result_ch.data.sun_elevation,
							e.sun_elevation);
					if (result_ch.data.sun_azimuth !== e.sun_azimuth)
						report_mismatch("sun_azimuth", result_ch.data.sun_azimuth,
							e.sun_azimuth);
				end
			end
			if (recv_wait > 0) begin
				result_ch.ready <= 1'b0;
				recv_wait <= recv_wait - 1;
			end else begin
				result_ch.ready <= 1'b1;
				if (result_ch.valid && result_ch.ready && $urandom_range(2) != 0)
					recv_wait <= $urandom_range(14);
			end
		end
	end

	// Timeout guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_site(input logic [CFG_INDEX_W-1:0] idx, input longint val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		// The write lands at this edge; track it in the predictor
		if (idx == REG_SITE_LATITUDE)
			site_lat = longint'($signed(val[LAT_W-1:0]));
		else if (idx == REG_SITE_LONGITUDE)
			site_lon = longint'($signed(val[LON_W-1:0]));
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait until the pipe has drained, then let it idle for the DRAIN_CYCLES margin
	task automatic drain_pipe();
		while (pending_samples.size() != 0 || sample_ch.valid || expected_pos.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_sample(input int day, input int minute);
		sample_t s;
		s.day_of_year   = day[8:0];
		s.minute_of_day = minute[10:0];
		pending_samples.push_back(s);
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				queue_sample($urandom_range(511), $urandom_range(2047));
			else
				queue_sample($urandom_range(366, 1), $urandom_range(1439));
		end
	endtask

	initial begin
		longint lats [6] = '{0, 92160, -92160, 131071, -131072, 48000};
		longint lons [6] = '{0, 184320, -184320, 262143, -262144, -9000};
		site_lat = 0;
		site_lon = 0;
		mismatch_count = 0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.wdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset site, field extremes and out-of-range values
		queue_sample(1, 0);
		queue_sample(366, 1439);
		queue_sample(0, 0);
		queue_sample(511, 2047);
		queue_sample(172, 720);
		queue_sample(355, 720);
		queue_sample(80, 360);
		queue_sample(1, 1440);
		drain_pipe();

		// Sweep sites, extremes included
		for (int k = 0; k < 6; k++) begin
			write_site(REG_SITE_LATITUDE, lats[k]);
			write_site(REG_SITE_LONGITUDE, lons[k]);
			queue_sample(172, 720);
			queue_sample(355, 0);
			queue_random(20);
			drain_pipe();
		end
		// Unlisted index is ignored
		write_site(4'd7, 12345);

		for (int k = 0; k < 10; k++) begin
			write_site(REG_SITE_LATITUDE, longint'($urandom_range(262143)) - 131072);
			write_site(REG_SITE_LONGITUDE, longint'($urandom_range(524287)) - 262144);
			queue_random(45);
			drain_pipe();
		end

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* solar_position_calc.f */
hdl/spc_pkg.sv
hdl/spc_sample_if.sv
hdl/spc_result_if.sv
hdl/spc_cfg_if.sv
hdl/spc_delay.sv
hdl/spc_sincos.sv
hdl/spc_atan2.sv
hdl/spc_isqrt.sv
hdl/solar_position_calc.sv
hdl/spc_sva.sv
tb/tb_top.sv
